// File: design/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
package owm_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int LONG_W     = 10;

    localparam logic [2:0] OP_RESET      = 3'd0;
    localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
    localparam logic [2:0] OP_READ_BIT   = 3'd3;
    localparam logic [2:0] OP_READ_BYTE  = 3'd4;

    localparam logic [2:0] REG_RESET_LOW_TIME   = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT    = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVERY   = 3'd2;
    localparam logic [2:0] REG_SLOT_START_LOW   = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT_REST  = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE_WAIT = 3'd5;
    localparam logic [2:0] REG_READ_SLOT_REST   = 3'd6;
    localparam logic [2:0] REG_SLOT_RECOVERY    = 3'd7;

    localparam logic [9:0] RST_RESET_LOW_TIME   = 10'd496;
    localparam logic [9:0] RST_PRESENCE_WAIT    = 10'd65;
    localparam logic [9:0] RST_RESET_RECOVERY   = 10'd424;
    localparam logic [3:0] RST_SLOT_START_LOW   = 4'd1;
    localparam logic [7:0] RST_WRITE_SLOT_REST  = 8'd66;
    localparam logic [7:0] RST_READ_SAMPLE_WAIT = 8'd15;
    localparam logic [7:0] RST_READ_SLOT_REST   = 8'd66;
    localparam logic [7:0] RST_SLOT_RECOVERY    = 8'd2;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait;
        logic [9:0] reset_recovery;
        logic [3:0] slot_start_low;
        logic [7:0] write_slot_rest;
        logic [7:0] read_sample_wait;
        logic [7:0] read_slot_rest;
        logic [7:0] slot_recovery;
    } cfg_t;

endpackage

// File: design/owm_if.sv
// Command/tick and result channel interfaces.
interface owm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       bus_level;

    modport source (output valid, kind, operation, write_data, bus_level, input ready);
    modport sink (input valid, kind, operation, write_data, bus_level, output ready);
endinterface

interface owm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;

    modport source (output valid, drive_low, busy_res, done_res, read_data, presence,
                    rejected, input ready);
    modport sink (input valid, drive_low, busy_res, done_res, read_data, presence,
                  rejected, output ready);
endinterface

// File: design/onewire_bus_master.sv
// Top level of the 1-Wire bus master.
// A result beat appears in the cycle after its command or tick beat is taken.
// Throughput: one beat per cycle while out_ch.ready is high; the output register frees as its beat is taken.
// The phase timer compare and state update sit between the state and result registers.
// Reset (rst_n low, async): bus idle, presence cleared, timing registers to defaults.
module onewire_bus_master
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    owm_in_if.sink                in_ch,
    owm_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    owm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// File: design/owm_cfg_regs.sv
// APB timing register file.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time   <= RST_RESET_LOW_TIME;
            cfg_reg.presence_wait    <= RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery   <= RST_RESET_RECOVERY;
            cfg_reg.slot_start_low   <= RST_SLOT_START_LOW;
            cfg_reg.write_slot_rest  <= RST_WRITE_SLOT_REST;
            cfg_reg.read_sample_wait <= RST_READ_SAMPLE_WAIT;
            cfg_reg.read_slot_rest   <= RST_READ_SLOT_REST;
            cfg_reg.slot_recovery    <= RST_SLOT_RECOVERY;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_RESET_LOW_TIME:   cfg_reg.reset_low_time   <= pwdata[9:0];
                REG_PRESENCE_WAIT:    cfg_reg.presence_wait    <= pwdata[9:0];
                REG_RESET_RECOVERY:   cfg_reg.reset_recovery   <= pwdata[9:0];
                REG_SLOT_START_LOW:   cfg_reg.slot_start_low   <= pwdata[3:0];
                REG_WRITE_SLOT_REST:  cfg_reg.write_slot_rest  <= pwdata[7:0];
                REG_READ_SAMPLE_WAIT: cfg_reg.read_sample_wait <= pwdata[7:0];
                REG_READ_SLOT_REST:   cfg_reg.read_slot_rest   <= pwdata[7:0];
                REG_SLOT_RECOVERY:    cfg_reg.slot_recovery    <= pwdata[7:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RESET_LOW_TIME:   prdata = CFG_DATA_W'(cfg_reg.reset_low_time);
            REG_PRESENCE_WAIT:    prdata = CFG_DATA_W'(cfg_reg.presence_wait);
            REG_RESET_RECOVERY:   prdata = CFG_DATA_W'(cfg_reg.reset_recovery);
            REG_SLOT_START_LOW:   prdata = CFG_DATA_W'(cfg_reg.slot_start_low);
            REG_WRITE_SLOT_REST:  prdata = CFG_DATA_W'(cfg_reg.write_slot_rest);
            REG_READ_SAMPLE_WAIT: prdata = CFG_DATA_W'(cfg_reg.read_sample_wait);
            REG_READ_SLOT_REST:   prdata = CFG_DATA_W'(cfg_reg.read_slot_rest);
            REG_SLOT_RECOVERY:    prdata = CFG_DATA_W'(cfg_reg.slot_recovery);
            default:              prdata = '0;
        endcase
    end

endmodule

// File: design/owm_engine.sv
// Bus timing state machine with registered result beat.
module owm_engine
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    owm_in_if.sink    in_ch,
    owm_out_if.source out_ch
);

    localparam int LEN_W = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;
    localparam logic [LEN_W-1:0] TIMER_MAX = LEN_W'((64'd1 << TIMER_BITS) - 64'd1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_SLOT_LOW,
        PH_WR_REST,
        PH_RD_WAIT,
        PH_RD_REST,
        PH_GAP
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [2:0]            op_reg, op_next;
    logic                  pres_reg, pres_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  drive_reg, busy_reg, done_reg, rej_reg;
    logic [7:0]            rdata_reg;

    logic                  accept;
    logic [LONG_W-1:0]     dur;
    logic [LEN_W-1:0]      dur_ext;
    logic [TIMER_BITS-1:0] len;
    logic [TIMER_BITS-1:0] cnt;
    logic                  done_c, rej_c, drive_c;
    logic                  read_op;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  dur = cfg.reset_low_time;
            PH_RST_WAIT: dur = cfg.presence_wait;
            PH_RST_REC:  dur = cfg.reset_recovery;
            PH_SLOT_LOW: dur = LONG_W'(cfg.slot_start_low);
            PH_WR_REST:  dur = LONG_W'(cfg.write_slot_rest);
            PH_RD_WAIT:  dur = LONG_W'(cfg.read_sample_wait);
            PH_RD_REST:  dur = LONG_W'(cfg.read_slot_rest);
            default:     dur = LONG_W'(cfg.slot_recovery);
        endcase
        dur_ext = LEN_W'(dur);
        if (dur_ext == '0)
        begin
            dur_ext = LEN_W'(1);
        end
        if (dur_ext > TIMER_MAX)
        begin
            dur_ext = TIMER_MAX;
        end
        len = dur_ext[TIMER_BITS-1:0];
    end

    assign cnt = tick_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        op_next    = op_reg;
        pres_next  = pres_reg;
        done_c     = 1'b0;
        rej_c      = 1'b0;

        if (in_ch.kind)
        begin
            if (phase_reg != PH_IDLE || in_ch.operation > OP_READ_BYTE)
            begin
                rej_c = 1'b1;
            end
            else
            begin
                op_next   = in_ch.operation;
                tick_next = '0;
                bit_next  = '0;
                case (in_ch.operation)
                    OP_RESET:
                    begin
                        shift_next = '0;
                        phase_next = PH_RST_LOW;
                    end
                    OP_WRITE_BIT:
                    begin
                        shift_next = {7'd0, in_ch.write_data[0]};
                        phase_next = PH_SLOT_LOW;
                    end
                    OP_WRITE_BYTE:
                    begin
                        shift_next = in_ch.write_data;
                        phase_next = PH_SLOT_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_SLOT_LOW;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (cnt < len && cnt != '0)
            begin
                tick_next = cnt;
            end
            else
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next = !in_ch.bus_level;
                        if (cfg.reset_recovery == '0)
                        begin
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RST_REC;
                        end
                    end
                    PH_RST_REC:
                    begin
                        phase_next = PH_IDLE;
                        done_c     = 1'b1;
                    end
                    PH_SLOT_LOW:
                    begin
                        if (op_reg == OP_READ_BIT || op_reg == OP_READ_BYTE)
                        begin
                            phase_next = PH_RD_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_WR_REST;
                        end
                    end
                    PH_WR_REST:
                    begin
                        phase_next = PH_GAP;
                    end
                    PH_RD_WAIT:
                    begin
                        if (in_ch.bus_level)
                        begin
                            shift_next[bit_reg] = 1'b1;
                        end
                        phase_next = (cfg.read_slot_rest == '0) ? PH_GAP : PH_RD_REST;
                    end
                    PH_RD_REST:
                    begin
                        phase_next = PH_GAP;
                    end
                    default:
                    begin
                        if (op_reg == OP_WRITE_BIT || op_reg == OP_READ_BIT
                            || bit_reg == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                            done_c     = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_SLOT_LOW;
                        end
                    end
                endcase
            end
        end

        case (phase_next)
            PH_RST_LOW, PH_SLOT_LOW: drive_c = 1'b1;
            PH_WR_REST:              drive_c = !shift_next[bit_next];
            default:                 drive_c = 1'b0;
        endcase
        read_op = (op_next == OP_READ_BIT) || (op_next == OP_READ_BYTE);
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            op_reg        <= '0;
            pres_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rdata_reg     <= '0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                op_reg    <= op_next;
                pres_reg  <= pres_next;
                drive_reg <= drive_c;
                busy_reg  <= (phase_next != PH_IDLE);
                done_reg  <= done_c;
                rdata_reg <= read_op ? shift_next : 8'd0;
                rej_reg   <= rej_c;
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.drive_low = drive_reg;
    assign out_ch.busy_res  = busy_reg;
    assign out_ch.done_res  = done_reg;
    assign out_ch.read_data = rdata_reg;
    assign out_ch.presence  = pres_reg;
    assign out_ch.rejected  = rej_reg;

endmodule
